[sv/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/b26e_pkg.sv]
// Shared types, constants and the base-26 divide step for the encoder.
`timescale 1ns / 1ps
`default_nettype none
package b26e_pkg;

  localparam int unsigned RADIX       = 26;
  localparam int unsigned LETTER_BASE = 65;
  localparam int unsigned LEN_MUL     = 851;
  localparam int unsigned LEN_ADD     = 499;
  localparam int unsigned LEN_DIV     = 500;
  localparam int unsigned REM_W       = 5;
  localparam int unsigned FRAC_W      = 9;

  // Control from the sequencer to the digit-count tracker.
  typedef struct packed {
    logic add;   // one byte stored
    logic dec;   // one letter sent
    logic clr;   // message done
  } len_ctl_t;

  typedef struct packed {
    logic [7:0]       quo;
    logic [REM_W-1:0] rem;
  } div_res_t;

  // One byte digit of long division by 26: (rem*256 + b) / 26, rem < 26.
  function automatic div_res_t div26(input logic [REM_W-1:0] rem_in,
                                     input logic [7:0] b);
    div_res_t         res;
    logic [REM_W-1:0] r;
    logic [REM_W:0]   t;
    r = rem_in;
    res.quo = '0;
    for (int i = 7; i >= 0; i--) begin
      t = {r, b[i]};
      if (t >= (REM_W+1)'(RADIX)) begin
        res.quo[i] = 1'b1;
        r = REM_W'(t - (REM_W+1)'(RADIX));
      end else begin
        r = t[REM_W-1:0];
      end
    end
    res.rem = r;
    return res;
  endfunction

endpackage
`default_nettype wire

[sv/b26e_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module b26e_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

[sv/b26e_len.sv]
// Letter-count tracker: accumulates ceil-style (n*851+499)/500 as bytes arrive.
`timescale 1ns / 1ps
`default_nettype none
module b26e_len
  import b26e_pkg::*;
#(
  parameter int DIG_W = 6
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire len_ctl_t         ctl,
  output logic      [DIG_W-1:0] dig_r
);

  localparam int unsigned STEP = LEN_MUL - LEN_DIV;  // 351

  logic [FRAC_W-1:0] frac_r, frac_nxt;
  logic [DIG_W-1:0]  dig_nxt;
  logic [FRAC_W:0]   sum;

  // Each byte adds 851/500 = 1 + 351/500 letters; the fraction starts at 499
  always_comb begin
    sum      = (FRAC_W+1)'(frac_r) + (FRAC_W+1)'(STEP);
    frac_nxt = frac_r;
    dig_nxt  = dig_r;
    if (ctl.clr) begin
      frac_nxt = FRAC_W'(LEN_ADD);
      dig_nxt  = '0;
    end else if (ctl.add) begin
      if (sum >= (FRAC_W+1)'(LEN_DIV)) begin
        frac_nxt = FRAC_W'(sum - (FRAC_W+1)'(LEN_DIV));
        dig_nxt  = dig_r + DIG_W'(2);
      end else begin
        frac_nxt = sum[FRAC_W-1:0];
        dig_nxt  = dig_r + DIG_W'(1);
      end
    end else if (ctl.dec) begin
      dig_nxt = dig_r - DIG_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_r <= FRAC_W'(LEN_ADD);
      dig_r  <= '0;
    end else begin
      frac_r <= frac_nxt;
      dig_r  <= dig_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/base26_byte_encoder.sv]
// Top level of the base-26 byte encoder: load sequencer and division passes.
//
// Usage: bytes of a message enter least significant first on in_data_byte,
// one byte per cycle, accepted on a rising edge with start high and busy low.
// in_last_byte marks the final byte. Bytes beyond MAX_BYTES are dropped, but
// a dropped last byte still ends the message.
// After the last byte, busy rises and the block emits (n*851+499)/500 letters
// 'A'..'Z', least significant base-26 digit first. Each letter is shown for
// one cycle with out_valid high; out_last_letter marks the final one.
// Each letter costs one long-division pass over the n stored bytes in the
// byte RAM, one byte per cycle through its single read port: n reads, a
// drain of the registered read data, then the letter's output cycle. The first
// letter is shown once the first pass ends; busy falls on the edge that ends
// the last letter's cycle.
// The receiver cannot stall; letters are sent on fixed cycles.
// Reset (rst_n low, synchronous) empties the message and returns to idle;
// RAM contents need no clearing since only bytes of the current message
// are read.
`timescale 1ns / 1ps
`default_nettype none
module base26_byte_encoder
  import b26e_pkg::*;
#(
  parameter int MAX_BYTES = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  output logic [6:0]      out_letter,
  output logic            out_last_letter
);

  localparam int AW      = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CNT_W   = $clog2(MAX_BYTES + 1);
  localparam int MAX_DIG = (MAX_BYTES * LEN_MUL + LEN_ADD) / LEN_DIV;
  localparam int DIG_W   = $clog2(MAX_DIG + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PASS = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]    rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]    wr_idx_r, wr_idx_nxt;
  logic             issue_r, issue_nxt;
  logic             pv_r, pv_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;

  logic             accept;
  logic             room;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [7:0]       ram_wdata;
  logic [7:0]       ram_rdata;
  div_res_t         div;
  len_ctl_t         len_ctl;
  logic [DIG_W-1:0] dig_left;
  logic             final_letter;

  assign busy         = (state_r != S_IDLE);
  assign accept       = start && !busy;
  assign room         = (cnt_r < CNT_W'(MAX_BYTES));
  assign div          = div26(rem_r, ram_rdata);
  assign final_letter = (dig_left == DIG_W'(1));

  // Byte store: loads in idle, quotient write-back during a pass
  assign ram_we    = (accept && room) || pv_r;
  assign ram_waddr = pv_r ? wr_idx_r : cnt_r[AW-1:0];
  assign ram_wdata = pv_r ? div.quo : in_data_byte;

  b26e_ram #(
    .WIDTH (8),
    .DEPTH (MAX_BYTES),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (rd_idx_r),
    .rdata_r (ram_rdata)
  );

  b26e_len #(
    .DIG_W (DIG_W)
  ) u_len (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (len_ctl),
    .dig_r (dig_left)
  );

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    rd_idx_nxt = rd_idx_r;
    wr_idx_nxt = wr_idx_r;
    issue_nxt  = 1'b0;
    pv_nxt     = 1'b0;
    rem_nxt    = rem_r;
    len_ctl    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (room) begin
            cnt_nxt     = cnt_r + CNT_W'(1);
            len_ctl.add = 1'b1;
          end
          if (in_last_byte) begin
            state_nxt  = S_PASS;
            issue_nxt  = 1'b1;
            rem_nxt    = '0;
            rd_idx_nxt = room ? cnt_r[AW-1:0] : AW'(MAX_BYTES - 1);
          end
        end
      end
      S_PASS: begin
        // read side: walk from the top byte down
        if (issue_r) begin
          pv_nxt     = 1'b1;
          wr_idx_nxt = rd_idx_r;
          if (rd_idx_r != '0) begin
            rd_idx_nxt = rd_idx_r - AW'(1);
            issue_nxt  = 1'b1;
          end
        end
        // divide side: one byte digit per cycle
        if (pv_r) begin
          rem_nxt = div.rem;
          if (wr_idx_r == '0) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (final_letter) begin
          state_nxt   = S_IDLE;
          cnt_nxt     = '0;
          len_ctl.clr = 1'b1;
        end else begin
          state_nxt   = S_PASS;
          len_ctl.dec = 1'b1;
          issue_nxt   = 1'b1;
          rem_nxt     = '0;
          rd_idx_nxt  = AW'(cnt_r - CNT_W'(1));
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      issue_r <= 1'b0;
      pv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      issue_r <= issue_nxt;
      pv_r    <= pv_nxt;
    end
  end

  // Pass payload registers
  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
    wr_idx_r <= wr_idx_nxt;
    rem_r    <= rem_nxt;
  end

  // Letter output
  assign out_valid       = (state_r == S_EMIT);
  assign out_letter      = 7'(rem_r) + 7'(LETTER_BASE);
  assign out_last_letter = final_letter;

endmodule
`default_nettype wire

[sv/b26e_chk.sv]
// Port-level checker for the base-26 encoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module b26e_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       in_last_byte,
  input wire logic       out_valid,
  input wire logic [6:0] out_letter,
  input wire logic       out_last_letter
);

  logic accept;
  assign accept = start && !busy;

  // letters stay in 'A'..'Z' and only come while busy
  `ASSERT_IMPLY(a_letter_range, clk, rst_n, out_valid,
                busy && out_letter >= 7'd65 && out_letter <= 7'd90)
  // a word that ends the message starts encoding
  `ASSERT_NEXT(a_last_starts, clk, rst_n, accept && in_last_byte, busy && !out_valid)
  // a plain word keeps the block idle
  `ASSERT_NEXT(a_load_idle, clk, rst_n, accept && !in_last_byte, !busy)
  // the final letter releases the block
  `ASSERT_NEXT(a_last_done, clk, rst_n, out_valid && out_last_letter, !busy && !out_valid)
  // a letter other than the final one is followed by a division pass, not by another letter
  `ASSERT_NEXT(a_gap, clk, rst_n, out_valid && !out_last_letter, busy && !out_valid)

endmodule

bind base26_byte_encoder b26e_chk u_chk (.*);
`default_nettype wire
